// ===== hdl/dasp_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual-axis step pulse counter package
// Shared widths, command codes and the control and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package dasp_pkg;

    // Field and state widths
    localparam int CmdWidth    = 3;
    localparam int AmountWidth = 16;
    localparam int CountWidth  = 24;
    localparam int RateWidth   = 15;
    localparam int MicroWidth  = 5;
    localparam int PeriodWidth = 20;
    localparam int CfgIdxWidth = 1;
    localparam int CfgWidth    = 15;
    localparam int DivCntWidth = 5;

    // Timer ticks in one second
    localparam logic [PeriodWidth-1:0] TicksPerSecond = 20'd1000000;

    // Command codes
    localparam logic [CmdWidth-1:0] CMD_TICK     = 3'd0;
    localparam logic [CmdWidth-1:0] CMD_MOVE_X   = 3'd1;
    localparam logic [CmdWidth-1:0] CMD_MOVE_Y   = 3'd2;
    localparam logic [CmdWidth-1:0] CMD_STOP_X   = 3'd3;
    localparam logic [CmdWidth-1:0] CMD_STOP_Y   = 3'd4;
    localparam logic [CmdWidth-1:0] CMD_STOP_ALL = 3'd5;

    // Configuration register indexes
    localparam logic [CfgIdxWidth-1:0] REG_STEP_RATE  = 1'd0;
    localparam logic [CfgIdxWidth-1:0] REG_MICROSTEPS = 1'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // commit the accepted transaction to the axis state
        logic div_step;  // run one bit of the period division
        logic load_out;  // capture the result register
    } ctrl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_needed; // the offered nonzero move starts from idle
        logic div_last;   // the division is on its final bit
    } status_t;

endpackage

// ===== hdl/dasp_in_if.sv =====
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command or timer tick per transaction.
// ----------------------------------------------------------------------------
interface dasp_in_if;

    logic                                    valid;
    logic                                    ready;
    logic [dasp_pkg::CmdWidth-1:0]           cmd;
    logic signed [dasp_pkg::AmountWidth-1:0] step_amount;

    modport source (output valid, output cmd, output step_amount, input ready);
    modport sink   (input valid, input cmd, input step_amount, output ready);

endinterface

// ===== hdl/dasp_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the step, direction and count lines.
// ----------------------------------------------------------------------------
interface dasp_out_if;

    logic                                   valid;
    logic                                   ready;
    logic                                   step_x;
    logic                                   step_y;
    logic                                   dir_x;
    logic                                   dir_y;
    logic signed [dasp_pkg::CountWidth-1:0] left_x;
    logic signed [dasp_pkg::CountWidth-1:0] left_y;
    logic                                   running;

    modport source (output valid, output step_x, output step_y, output dir_x,
                    output dir_y, output left_x, output left_y, output running,
                    input ready);
    modport sink   (input valid, input step_x, input step_y, input dir_x,
                    input dir_y, input left_x, input left_y, input running,
                    output ready);

endinterface

// ===== hdl/dasp_datapath.sv =====
// ----------------------------------------------------------------------------
// Dual-axis step pulse counter datapath
// Configuration registers, axis counters, step phase, the bit-serial period
// divider and the result register.
// ----------------------------------------------------------------------------
module dasp_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [dasp_pkg::CfgIdxWidth-1:0]        cfg_index,
    input  logic [dasp_pkg::CfgWidth-1:0]           cfg_data,
    input  logic [dasp_pkg::CmdWidth-1:0]           cmd,
    input  logic signed [dasp_pkg::AmountWidth-1:0] step_amount,
    input  dasp_pkg::ctrl_t                         ctrl,
    output dasp_pkg::status_t                       status,
    output logic                                    step_x,
    output logic                                    step_y,
    output logic                                    dir_x,
    output logic                                    dir_y,
    output logic signed [dasp_pkg::CountWidth-1:0]  left_x,
    output logic signed [dasp_pkg::CountWidth-1:0]  left_y,
    output logic                                    running
);

    localparam int CW = dasp_pkg::CountWidth;
    localparam int PW = dasp_pkg::PeriodWidth;
    localparam int MW = dasp_pkg::AmountWidth + dasp_pkg::MicroWidth;

    logic [dasp_pkg::RateWidth-1:0]   rate_reg;
    logic [dasp_pkg::MicroWidth-1:0]  micro_reg;
    logic signed [CW-1:0]             rem_x_reg, rem_x_next;
    logic signed [CW-1:0]             rem_y_reg, rem_y_next;
    logic                             dir_x_reg, dir_x_next;
    logic                             dir_y_reg, dir_y_next;
    logic [PW-1:0]                    period_reg, period_next;
    logic [PW-1:0]                    phase_reg, phase_next;
    logic [PW-1:0]                    divisor_reg;
    logic [PW:0]                      div_rem_reg;
    logic [PW-1:0]                    div_quo_reg;
    logic [dasp_pkg::DivCntWidth-1:0] div_cnt_reg;

    logic [dasp_pkg::RateWidth-1:0]   rate_eff;
    logic [dasp_pkg::MicroWidth-1:0]  micro_eff;
    logic signed [MW-1:0]             move_delta;
    logic signed [CW-1:0]             move_x, move_y;
    logic                             axes_idle;
    logic                             amount_nz;
    logic [PW-1:0]                    phase_inc;
    logic [PW:0]                      div_shift;
    logic                             div_bit;
    logic [PW-1:0]                    div_quo_new;
    logic                             half_period;

    // Saturating add of a move to an axis count
    function automatic logic signed [CW-1:0] sat_add(
        input logic signed [CW-1:0] cnt,
        input logic signed [MW-1:0] delta
    );
        logic signed [CW:0] sum;
        sum = {cnt[CW-1], cnt} + {{(CW + 1 - MW){delta[MW-1]}}, delta};
        if (sum[CW] != sum[CW-1])
        begin
            sat_add = sum[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        else
        begin
            sat_add = sum[CW-1:0];
        end
    endfunction

    // One count toward zero
    function automatic logic signed [CW-1:0] toward_zero(
        input logic signed [CW-1:0] cnt
    );
        if (cnt == '0)
        begin
            toward_zero = '0;
        end
        else if (cnt[CW-1])
        begin
            toward_zero = cnt + CW'(1);
        end
        else
        begin
            toward_zero = cnt - CW'(1);
        end
    endfunction

    // Zero configuration values act as one
    assign rate_eff  = (rate_reg == '0) ? dasp_pkg::RateWidth'(1) : rate_reg;
    assign micro_eff = (micro_reg == '0) ? dasp_pkg::MicroWidth'(1) : micro_reg;

    // Move size in microsteps
    assign move_delta = $signed({{(MW - dasp_pkg::AmountWidth){step_amount[
                            dasp_pkg::AmountWidth-1]}}, step_amount})
                      * $signed({{(MW - dasp_pkg::MicroWidth){1'b0}}, micro_eff});
    assign move_x     = sat_add(rem_x_reg, move_delta);
    assign move_y     = sat_add(rem_y_reg, move_delta);
    assign axes_idle  = (rem_x_reg == '0) && (rem_y_reg == '0);
    assign amount_nz  = (step_amount != '0);
    assign phase_inc  = phase_reg + PW'(1);

    // A move from idle needs a fresh period
    assign status.div_needed = axes_idle && amount_nz &&
                               ((cmd == dasp_pkg::CMD_MOVE_X) ||
                                (cmd == dasp_pkg::CMD_MOVE_Y));
    assign status.div_last   = (div_cnt_reg == '0);

    // Restoring division, one quotient bit per cycle
    assign div_shift   = {div_rem_reg[PW-1:0], dasp_pkg::TicksPerSecond[div_cnt_reg]};
    assign div_bit     = (div_shift >= {1'b0, divisor_reg});
    assign div_quo_new = {div_quo_reg[PW-2:0], div_bit};

    // Next axis state
    always_comb
    begin
        rem_x_next  = rem_x_reg;
        rem_y_next  = rem_y_reg;
        dir_x_next  = dir_x_reg;
        dir_y_next  = dir_y_reg;
        period_next = period_reg;
        phase_next  = phase_reg;
        if (ctrl.accept)
        begin
            case (cmd)
                dasp_pkg::CMD_TICK:
                begin
                    if (!axes_idle)
                    begin
                        if (phase_inc >= period_reg)
                        begin
                            phase_next = '0;
                            rem_x_next = toward_zero(rem_x_reg);
                            rem_y_next = toward_zero(rem_y_reg);
                        end
                        else
                        begin
                            phase_next = phase_inc;
                        end
                    end
                end
                dasp_pkg::CMD_MOVE_X:
                begin
                    if (amount_nz)
                    begin
                        rem_x_next = move_x;
                        dir_x_next = move_x[CW-1];
                    end
                end
                dasp_pkg::CMD_MOVE_Y:
                begin
                    if (amount_nz)
                    begin
                        rem_y_next = move_y;
                        dir_y_next = move_y[CW-1];
                    end
                end
                dasp_pkg::CMD_STOP_X:
                begin
                    rem_x_next = '0;
                end
                dasp_pkg::CMD_STOP_Y:
                begin
                    rem_y_next = '0;
                end
                dasp_pkg::CMD_STOP_ALL:
                begin
                    rem_x_next = '0;
                    rem_y_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        if (ctrl.div_step && status.div_last)
        begin
            period_next = (div_quo_new == '0) ? PW'(1) : div_quo_new;
            phase_next  = '0;
        end
    end

    // Configuration and axis state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= dasp_pkg::RateWidth'(100);
            micro_reg  <= dasp_pkg::MicroWidth'(1);
            rem_x_reg  <= '0;
            rem_y_reg  <= '0;
            dir_x_reg  <= 1'b0;
            dir_y_reg  <= 1'b0;
            period_reg <= '0;
            phase_reg  <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == dasp_pkg::REG_STEP_RATE))
            begin
                rate_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == dasp_pkg::REG_MICROSTEPS))
            begin
                micro_reg <= cfg_data[dasp_pkg::MicroWidth-1:0];
            end
            rem_x_reg  <= rem_x_next;
            rem_y_reg  <= rem_y_next;
            dir_x_reg  <= dir_x_next;
            dir_y_reg  <= dir_y_next;
            period_reg <= period_next;
            phase_reg  <= phase_next;
        end
    end

    // Divider registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (ctrl.accept)
        begin
            div_cnt_reg <= dasp_pkg::DivCntWidth'(PW - 1);
        end
        else if (ctrl.div_step && !status.div_last)
        begin
            div_cnt_reg <= div_cnt_reg - dasp_pkg::DivCntWidth'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            divisor_reg <= {{(PW - dasp_pkg::RateWidth){1'b0}}, rate_eff}
                         * {{(PW - dasp_pkg::MicroWidth){1'b0}}, micro_eff};
            div_rem_reg <= '0;
            div_quo_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            div_rem_reg <= div_bit ? (div_shift - {1'b0, divisor_reg}) : div_shift;
            div_quo_reg <= div_quo_new;
        end
    end

    // Result register
    assign half_period = ({phase_reg, 1'b0} < {1'b0, period_reg});

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            step_x  <= (rem_x_reg != '0) && half_period;
            step_y  <= (rem_y_reg != '0) && half_period;
            dir_x   <= dir_x_reg;
            dir_y   <= dir_y_reg;
            left_x  <= rem_x_reg;
            left_y  <= rem_y_reg;
            running <= !axes_idle;
        end
    end

endmodule

// ===== hdl/dasp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Dual-axis step pulse counter controller
// Sequences accept, period division and result hand-off for one transaction.
// ----------------------------------------------------------------------------
module dasp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  dasp_pkg::status_t status,
    output dasp_pkg::ctrl_t   ctrl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // Take a transaction only once the result register is free
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    ctrl.accept = 1'b1;
                    state_next  = status.div_needed ? S_DIV : S_EMIT;
                end
            end
            S_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                ctrl.load_out  = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/dual_axis_step_pulse_counter.sv =====
// ----------------------------------------------------------------------------
// Dual-axis step pulse counter
// Two-axis step and direction generator driven by microsecond ticks and
// move/stop commands, with one result transaction per command.
// ----------------------------------------------------------------------------
// Each command transaction yields one result transaction that shows the step,
// direction and remaining-count lines after the command. Ticks, stops and moves
// onto a running axis go from accept through the emit state to the result; a move
// that starts from idle first runs the period division, since the step period
// (one million divided by step rate times microsteps) comes from a restoring
// divider that resolves one of its 20 quotient bits per cycle. A new command is
// taken as soon as the previous result has been taken or is being taken. Configuration
// writes reach the step period at the next start from idle; microsteps scale moves at once.
module dual_axis_step_pulse_counter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dasp_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  logic [dasp_pkg::CfgWidth-1:0]      cfg_data,
    dasp_in_if.sink                            cmd_chan,
    dasp_out_if.source                         result_chan
);

    dasp_pkg::ctrl_t   ctrl;
    dasp_pkg::status_t status;

    // Sequencing
    dasp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_chan.valid),
        .in_ready  (cmd_chan.ready),
        .out_valid (result_chan.valid),
        .out_ready (result_chan.ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    // Axis state, divider and result register
    dasp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd_chan.cmd),
        .step_amount (cmd_chan.step_amount),
        .ctrl        (ctrl),
        .status      (status),
        .step_x      (result_chan.step_x),
        .step_y      (result_chan.step_y),
        .dir_x       (result_chan.dir_x),
        .dir_y       (result_chan.dir_y),
        .left_x      (result_chan.left_x),
        .left_y      (result_chan.left_y),
        .running     (result_chan.running)
    );

    // Only one transaction is in flight at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_chan.valid && cmd_chan.ready) |=> !cmd_chan.ready)
        else $error("command accepted while another is in flight");

    // Loading the result register always presents a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |=> result_chan.valid)
        else $error("result loaded but not presented");

    // The divider never runs while commands are taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_step |-> !cmd_chan.ready)
        else $error("command port open during period division");

endmodule

// ===== test/dasp_line_checker.sv =====
// ----------------------------------------------------------------------------
// Step line checker
// Watches the command, result and register write traffic of the dual-axis
// step pulse counter, predicts the step, direction and count lines for every
// command transaction and compares each result transaction with the oldest
// prediction.
// ----------------------------------------------------------------------------
module dasp_line_checker
    import dasp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [CfgWidth-1:0]    cfg_data,
    dasp_in_if                     cmd_mon,
    dasp_out_if                    line_mon,
    output int                     fail_count,
    output int                     waiting
);

    localparam longint COUNT_MAX = longint'(2 ** (CountWidth - 1)) - 1;
    localparam longint COUNT_MIN = -COUNT_MAX - 1;

    // Lines that one result transaction should show
    typedef struct packed {
        logic                         step_x;
        logic                         step_y;
        logic                         dir_x;
        logic                         dir_y;
        logic signed [CountWidth-1:0] left_x;
        logic signed [CountWidth-1:0] left_y;
        logic                         running;
    } lines_t;

    // Our own copy of the registers and the axis state
    logic [RateWidth-1:0]         rate_reg;
    logic [MicroWidth-1:0]        micro_reg;
    logic signed [CountWidth-1:0] count_x;
    logic signed [CountWidth-1:0] count_y;
    logic                         sense_x;
    logic                         sense_y;
    logic [PeriodWidth-1:0]       period_ticks;
    logic [PeriodWidth-1:0]       phase_ticks;

    lines_t expected_lines [$];
    lines_t want;

    // Print one failure line and count it.
    task automatic report(input string text);
        $display("%0t: %s", $time, text);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] want_v,
                                 input logic signed [31:0] got_v);
        if (got_v !== want_v)
            report($sformatf("%s mismatch: expected %0d, got %0d", name, want_v, got_v));
    endtask

    function automatic logic signed [CountWidth-1:0] toward_rest(
        input logic signed [CountWidth-1:0] count);
        if (count > 0)
            return count - CountWidth'(1);
        if (count < 0)
            return count + CountWidth'(1);
        return count;
    endfunction

    // Add a move to one axis. A move that starts while both axes are at rest
    // latches a fresh step period from the current registers.
    function automatic void add_steps(inout logic signed [CountWidth-1:0] count,
                                      inout logic sense, input longint amount);
        longint      sum;
        longint      micro_eff;
        int unsigned rate_eff;
        int unsigned ticks;
        logic        from_rest;
        from_rest = (count_x == 0) && (count_y == 0);
        if (amount == 0)
            return;
        micro_eff = (micro_reg == 0) ? 1 : longint'(micro_reg);
        sum = longint'(count) + amount * micro_eff;
        if (sum > COUNT_MAX)
            sum = COUNT_MAX;
        if (sum < COUNT_MIN)
            sum = COUNT_MIN;
        count = sum[CountWidth-1:0];
        sense = (sum < 0);
        if (from_rest)
        begin
            rate_eff = (rate_reg == 0) ? 1 : int'(rate_reg);
            ticks = int'(TicksPerSecond) / rate_eff / int'(micro_eff);
            if (ticks == 0)
                ticks = 1;
            period_ticks = ticks[PeriodWidth-1:0];
            phase_ticks = '0;
        end
    endfunction

    // Apply one command to the predicted state and return the lines after it.
    function automatic lines_t predict_lines(input logic [CmdWidth-1:0] code,
                                             input logic signed [AmountWidth-1:0] amount);
        lines_t lines;
        logic   half;
        case (code)
            CMD_TICK:
            begin
                // The phase only advances while some axis has steps left.
                if (count_x != 0 || count_y != 0)
                begin
                    phase_ticks = phase_ticks + 1'b1;
                    if (phase_ticks >= period_ticks)
                    begin
                        phase_ticks = '0;
                        count_x = toward_rest(count_x);
                        count_y = toward_rest(count_y);
                    end
                end
            end
            CMD_MOVE_X:   add_steps(count_x, sense_x, longint'(amount));
            CMD_MOVE_Y:   add_steps(count_y, sense_y, longint'(amount));
            CMD_STOP_X:   count_x = '0;
            CMD_STOP_Y:   count_y = '0;
            CMD_STOP_ALL:
            begin
                count_x = '0;
                count_y = '0;
            end
            default: ;
        endcase
        half = {phase_ticks, 1'b0} < {1'b0, period_ticks};
        lines.step_x  = (count_x != 0) && half;
        lines.step_y  = (count_y != 0) && half;
        lines.dir_x   = sense_x;
        lines.dir_y   = sense_y;
        lines.left_x  = count_x;
        lines.left_y  = count_y;
        lines.running = (count_x != 0) || (count_y != 0);
        return lines;
    endfunction

    // Track register writes, check result transactions, then predict new commands.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg = 15'd100;
            micro_reg = 5'd1;
            count_x = '0;
            count_y = '0;
            sense_x = 1'b0;
            sense_y = 1'b0;
            period_ticks = '0;
            phase_ticks = '0;
            expected_lines.delete();
            waiting <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STEP_RATE:  rate_reg = cfg_data[RateWidth-1:0];
                    REG_MICROSTEPS: micro_reg = cfg_data[MicroWidth-1:0];
                    default: ;
                endcase
            end
            if (line_mon.valid && line_mon.ready)
            begin
                if (expected_lines.size() == 0)
                    report("result transaction with no expectation waiting");
                else
                begin
                    want = expected_lines.pop_front();
                    compare_field("step_x", want.step_x, line_mon.step_x);
                    compare_field("step_y", want.step_y, line_mon.step_y);
                    compare_field("dir_x", want.dir_x, line_mon.dir_x);
                    compare_field("dir_y", want.dir_y, line_mon.dir_y);
                    compare_field("left_x", want.left_x, line_mon.left_x);
                    compare_field("left_y", want.left_y, line_mon.left_y);
                    compare_field("running", want.running, line_mon.running);
                end
            end
            if (cmd_mon.valid && cmd_mon.ready)
                expected_lines.push_back(predict_lines(cmd_mon.cmd, cmd_mon.step_amount));
            waiting <= expected_lines.size();
        end
    end

endmodule

// ===== test/tb_dual_axis_step_pulse_counter.sv =====
// ----------------------------------------------------------------------------
// Dual-axis step pulse counter testbench
// Sends directed and random tick, move and stop transactions under several
// step rate and microstep settings, with random gaps on the command side and
// random stalls on the result side. A checker beside the block predicts and
// compares every result transaction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dual_axis_step_pulse_counter;
    import dasp_pkg::*;

    localparam int PHASES = 9;
    localparam int RANDOM_ITEMS = 120;
    localparam logic [CmdWidth-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CmdWidth-1:0] CMD_SPARE_HI = 3'd7;
    localparam logic signed [AmountWidth-1:0] AMOUNT_MAX = 16'sh7FFF;
    localparam logic signed [AmountWidth-1:0] AMOUNT_MIN = 16'sh8000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [CfgWidth-1:0]    cfg_data;
    int                     fail_count;
    int                     waiting;
    bit                     send_quiet;
    bit                     drain_quiet;
    int unsigned            hold;

    dasp_in_if  cmd_chan ();
    dasp_out_if result_chan ();

    dual_axis_step_pulse_counter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd_chan    (cmd_chan),
        .result_chan (result_chan)
    );

    dasp_line_checker line_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_mon    (cmd_chan),
        .line_mon   (result_chan),
        .fail_count (fail_count),
        .waiting    (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #20_000_000;
        $display("tb_dual_axis_step_pulse_counter: FAIL");
        $finish;
    end

    // Result side: mostly ready, with short and occasional long stalls.
    always @(posedge clk)
    begin : drain_pace
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (hold != 0)
        begin
            hold <= hold - 1;
            result_chan.ready <= 1'b0;
        end
        else if (drain_quiet || roll < 70)
            result_chan.ready <= 1'b1;
        else if (roll < 96)
        begin
            result_chan.ready <= 1'b0;
            hold <= $urandom_range(0, 2);
        end
        else
        begin
            result_chan.ready <= 1'b0;
            hold <= $urandom_range(10, 40);
        end
    end

    // Gap before the next command: mostly none or short, now and then long.
    function automatic int unsigned next_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (send_quiet || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one command transaction, wait for it to be taken, then idle a while.
    // Valid stays high when no gap follows.
    task automatic send_item(input logic [CmdWidth-1:0] code,
                             input logic signed [AmountWidth-1:0] amount,
                             input int unsigned gap);
        cmd_chan.valid <= 1'b1;
        cmd_chan.cmd <= code;
        cmd_chan.step_amount <= amount;
        @(posedge clk);
        while (!cmd_chan.ready)
            @(posedge clk);
        if (gap != 0)
        begin
            cmd_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        int unsigned                   rate;
        int unsigned                   micro;
        int unsigned                   sent;
        int unsigned                   roll;
        int unsigned                   pick;
        logic [CmdWidth-1:0]           code;
        logic signed [AmountWidth-1:0] amount;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_STEP_RATE;
        cfg_data = '0;
        cmd_chan.valid = 1'b0;
        cmd_chan.cmd = CMD_TICK;
        cmd_chan.step_amount = '0;
        result_chan.ready = 1'b0;
        hold = 0;
        send_quiet = 1'b0;
        drain_quiet = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // Register settings per phase, extremes included. The microstep
            // write in one phase carries junk in the unused upper bits.
            case (phase)
                0: begin rate = 32767; micro = 31; end
                1: begin rate = 32767; micro = 16; end
                2: begin rate = 5000;  micro = 4;  end
                3: begin rate = 1;     micro = 1;  end
                4: begin rate = 0;     micro = 0;  end
                5: begin rate = 20000; micro = 1;  end
                6: begin rate = 31250; micro = 8;  end
                7: begin rate = 700;   micro = 15'h7FE3; end
                default: begin rate = 32767; micro = 0; end
            endcase
            send_quiet = (phase % 3 == 2);
            drain_quiet <= (phase % 4 == 1);

            // Both registers are written back to back while nothing is in flight.
            cfg_we <= 1'b1;
            cfg_index <= REG_STEP_RATE;
            cfg_data <= rate[CfgWidth-1:0];
            @(posedge clk);
            cfg_index <= REG_MICROSTEPS;
            cfg_data <= micro[CfgWidth-1:0];
            @(posedge clk);
            cfg_we <= 1'b0;

            if (phase == 0)
            begin
                // Tick at rest, zero move, a move that lands on zero,
                // a sub-tick period, stops, unused codes and saturation both ways.
                send_item(CMD_TICK, 16'sd0, next_gap());
                send_item(CMD_MOVE_X, 16'sd0, next_gap());
                send_item(CMD_MOVE_X, 16'sd2, next_gap());
                send_item(CMD_MOVE_X, -16'sd2, next_gap());
                send_item(CMD_MOVE_Y, -16'sd1, next_gap());
                send_item(CMD_TICK, AMOUNT_MIN, next_gap());
                send_item(CMD_STOP_Y, AMOUNT_MAX, next_gap());
                send_item(CMD_SPARE_LO, AMOUNT_MAX, next_gap());
                send_item(CMD_SPARE_HI, AMOUNT_MIN, next_gap());
                repeat (9) send_item(CMD_MOVE_X, AMOUNT_MAX, next_gap());
                repeat (9) send_item(CMD_MOVE_Y, AMOUNT_MIN, next_gap());
                send_item(CMD_STOP_X, 16'sd0, next_gap());
                send_item(CMD_STOP_ALL, -16'sd1, next_gap());
            end

            // Random mix: mostly ticks so that axes run down, small moves, stops,
            // rare unused codes and rare bursts of extreme moves on one axis.
            sent = 0;
            while (sent < RANDOM_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                amount = 16'($urandom);
                if (roll < 68)
                    code = CMD_TICK;
                else if (roll < 83)
                begin
                    code = $urandom_range(0, 1) ? CMD_MOVE_X : CMD_MOVE_Y;
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                        amount = 16'(int'($urandom_range(0, 8)) - 4);
                    else if (pick == 8)
                        amount = AMOUNT_MAX;
                    else if (pick == 9)
                        amount = AMOUNT_MIN;
                end
                else if (roll < 95)
                begin
                    pick = $urandom_range(0, 2);
                    code = (pick == 0) ? CMD_STOP_X : (pick == 1) ? CMD_STOP_Y : CMD_STOP_ALL;
                end
                else if (roll < 98)
                    code = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
                else
                begin
                    code = $urandom_range(0, 1) ? CMD_MOVE_X : CMD_MOVE_Y;
                    amount = $urandom_range(0, 1) ? AMOUNT_MAX : AMOUNT_MIN;
                    repeat (11) send_item(code, amount, next_gap());
                    sent += 11;
                end
                send_item(code, amount, next_gap());
                if (code != CMD_SPARE_LO && code != CMD_SPARE_HI)
                    sent++;
            end
            cmd_chan.valid <= 1'b0;

            // Let every expected result arrive before the next register writes.
            // One clock first, so that the count includes the last transaction.
            @(posedge clk);
            while (waiting != 0)
                @(posedge clk);
        end

        repeat (30) @(posedge clk);
        if (fail_count == 0 && waiting == 0)
            $display("tb_dual_axis_step_pulse_counter: PASS");
        else
            $display("tb_dual_axis_step_pulse_counter: FAIL");
        $finish;
    end

endmodule
